// ===== rtl/matrix3x3_inverse_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the 3x3 matrix inverse
// Shared property shorthands for the checker files.
// ---------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define M3I_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define M3I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/m3i_pkg.sv =====
// ---------------------------------------------------------------------------
// 3x3 matrix inverse package
// Widths, pipeline depth and the cofactor index tables.
// ---------------------------------------------------------------------------
package m3i_pkg;

    localparam int ElemW  = 16;
    localparam int OutW   = 32;
    localparam int ProdW  = 2 * ElemW;
    localparam int CofW   = ProdW + 1;
    localparam int DetPW  = ElemW + CofW;
    localparam int DetW   = DetPW + 2;
    localparam int AbsCW  = 32;
    localparam int DivW   = 50;
    localparam int DivSteps = 34;
    localparam int HiW    = AbsCW - 5;

    typedef logic signed [ElemW-1:0] t_elem;
    typedef logic signed [OutW-1:0]  t_out;
    typedef logic [3:0]              t_idx;

    // Adjugate element i equals a[CA[i]]*a[CB[i]] - a[CC[i]]*a[CD[i]], row-major.
    localparam t_idx CA [9] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
    localparam t_idx CB [9] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
    localparam t_idx CC [9] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
    localparam t_idx CD [9] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

endpackage

// ===== rtl/matrix3x3_inverse.sv =====
// ---------------------------------------------------------------------------
// 3x3 matrix inverse
// Adjugate over determinant, Q4.12 in, saturated Q16.16 out.
// ---------------------------------------------------------------------------
// The block accepts one matrix every clock cycle unless the output stalls and
// returns its inverse via the input, product, cofactor and determinant
// registers, the division setup, 34 restoring division steps (one quotient
// bit per step, nine lanes in parallel) and one rounding and saturation
// stage. A stall at the output freezes the whole pipeline; nothing is lost.
module matrix3x3_inverse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  m3i_pkg::t_elem i_elem_00, i_elem_01, i_elem_02,
    input  m3i_pkg::t_elem i_elem_10, i_elem_11, i_elem_12,
    input  m3i_pkg::t_elem i_elem_20, i_elem_21, i_elem_22,
    output logic           o_valid,
    input  logic           i_stall,
    output m3i_pkg::t_out  o_inv_00, o_inv_01, o_inv_02,
    output m3i_pkg::t_out  o_inv_10, o_inv_11, o_inv_12,
    output m3i_pkg::t_out  o_inv_20, o_inv_21, o_inv_22,
    output logic           o_singular,
    output logic           o_overflow
);
    import m3i_pkg::*;

    localparam int NSt = DivSteps + 7;

    logic en;
    logic [NSt-1:0] r_vld;

    t_elem r_a [9];
    logic signed [ProdW-1:0] r_pa [9], r_pb [9];
    logic signed [CofW-1:0] r_c3 [9], r_c4 [9], r_c5 [9];
    t_elem r_col3 [3], r_col2 [3];
    logic signed [DetPW-1:0] r_dp [3];
    logic signed [DetW-1:0] r_det;

    logic [DivW-1:0]     r_rem [DivSteps+1][9];
    logic [DivSteps-1:0] r_nl  [DivSteps+1][9];
    logic [DivSteps-1:0] r_q   [DivSteps+1][9];
    logic [8:0]          r_neg [DivSteps+1];
    logic [8:0]          r_ovr [DivSteps+1];
    logic [DivW-1:0]     r_d   [DivSteps+1];
    logic                r_sng [DivSteps+1];

    t_out r_inv [9];
    logic r_sing, r_ovf;

    // The pipeline moves unless a finished result is held back.
    assign en      = !(r_vld[NSt-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NSt-1];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSt-2:0], i_valid};
        end
    end

    // Input register, products, cofactors, determinant.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= '{i_elem_00, i_elem_01, i_elem_02, i_elem_10, i_elem_11,
                     i_elem_12, i_elem_20, i_elem_21, i_elem_22};
            for (int i = 0; i < 9; i++) begin
                r_pa[i] <= r_a[CA[i]] * r_a[CB[i]];
                r_pb[i] <= r_a[CC[i]] * r_a[CD[i]];
                r_c3[i] <= CofW'(r_pa[i]) - CofW'(r_pb[i]);
            end
            r_col2 <= '{r_a[0], r_a[3], r_a[6]};
            r_col3 <= r_col2;
            for (int i = 0; i < 3; i++) begin
                r_dp[i] <= r_col3[i] * r_c3[i];
            end
            r_c4  <= r_c3;
            r_det <= DetW'(r_dp[0]) + DetW'(r_dp[1]) + DetW'(r_dp[2]);
            r_c5  <= r_c4;
        end
    end

    // Division setup: magnitudes, signs and the out-of-range check.
    always_ff @(posedge i_clk) begin
        logic [AbsCW-1:0] n_absc;
        logic [DetW-1:0]  n_absd;
        if (en) begin
            n_absd = r_det[DetW-1] ? DetW'(-r_det) : DetW'(r_det);
            r_d[0]   <= n_absd[DivW-1:0];
            r_sng[0] <= (r_det == '0);
            for (int i = 0; i < 9; i++) begin
                n_absc = r_c5[i][CofW-1] ? AbsCW'(-r_c5[i]) : AbsCW'(r_c5[i]);
                r_rem[0][i] <= DivW'(n_absc[AbsCW-1:5]);
                r_nl[0][i]  <= {n_absc[4:0], 29'b0};
                r_q[0][i]   <= '0;
                r_neg[0][i] <= r_c5[i][CofW-1] ^ r_det[DetW-1];
                r_ovr[0][i] <= DivW'(n_absc[AbsCW-1:5]) >= n_absd[DivW-1:0];
            end
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar s = 1; s <= DivSteps; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [DivW:0] n_t;
            if (en) begin
                r_d[s]   <= r_d[s-1];
                r_sng[s] <= r_sng[s-1];
                r_neg[s] <= r_neg[s-1];
                r_ovr[s] <= r_ovr[s-1];
                for (int i = 0; i < 9; i++) begin
                    n_t = {r_rem[s-1][i], r_nl[s-1][i][DivSteps-1]};
                    r_nl[s][i] <= {r_nl[s-1][i][DivSteps-2:0], 1'b0};
                    if (n_t >= {1'b0, r_d[s-1]}) begin
                        r_rem[s][i] <= DivW'(n_t - {1'b0, r_d[s-1]});
                        r_q[s][i]   <= {r_q[s-1][i][DivSteps-2:0], 1'b1};
                    end else begin
                        r_rem[s][i] <= n_t[DivW-1:0];
                        r_q[s][i]   <= {r_q[s-1][i][DivSteps-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Rounding to nearest, saturation and the singular override.
    always_ff @(posedge i_clk) begin
        logic [DivSteps:0] n_q;
        logic              n_sat;
        logic              n_any;
        if (en) begin
            n_any = 1'b0;
            for (int i = 0; i < 9; i++) begin
                n_q = ({1'b0, r_q[DivSteps][i]} + 1'b1) >> 1;
                n_sat = r_ovr[DivSteps][i] ||
                        (r_neg[DivSteps][i] ? (n_q > (DivSteps+1)'(33'h080000000))
                                            : (n_q > (DivSteps+1)'(33'h07FFFFFFF)));
                if (r_sng[DivSteps]) begin
                    r_inv[i] <= '0;
                end else if (n_sat) begin
                    r_inv[i] <= r_neg[DivSteps][i] ? 32'sh80000000 : 32'sh7FFFFFFF;
                end else begin
                    r_inv[i] <= r_neg[DivSteps][i] ? OutW'(-n_q) : OutW'(n_q);
                end
                n_any = n_any | n_sat;
            end
            r_sing <= r_sng[DivSteps];
            r_ovf  <= n_any && !r_sng[DivSteps];
        end
    end

    assign o_inv_00 = r_inv[0];
    assign o_inv_01 = r_inv[1];
    assign o_inv_02 = r_inv[2];
    assign o_inv_10 = r_inv[3];
    assign o_inv_11 = r_inv[4];
    assign o_inv_12 = r_inv[5];
    assign o_inv_20 = r_inv[6];
    assign o_inv_21 = r_inv[7];
    assign o_inv_22 = r_inv[8];
    assign o_singular = r_sing;
    assign o_overflow = r_ovf;

endmodule

// ===== rtl/m3i_checker.sv =====
// ---------------------------------------------------------------------------
// 3x3 matrix inverse checker
// Port-level checks, bound to the top level.
// ---------------------------------------------------------------------------
`include "matrix3x3_inverse_assert.svh"

module m3i_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input m3i_pkg::t_out o_inv_00, o_inv_01, o_inv_02,
    input m3i_pkg::t_out o_inv_10, o_inv_11, o_inv_12,
    input m3i_pkg::t_out o_inv_20, o_inv_21, o_inv_22,
    input logic          o_singular,
    input logic          o_overflow
);
    import m3i_pkg::*;

    logic all_zero, any_sat;

    assign all_zero = (o_inv_00 == '0) && (o_inv_01 == '0) && (o_inv_02 == '0) &&
                      (o_inv_10 == '0) && (o_inv_11 == '0) && (o_inv_12 == '0) &&
                      (o_inv_20 == '0) && (o_inv_21 == '0) && (o_inv_22 == '0);

    function automatic logic is_lim(input t_out v);
        is_lim = (v == 32'sh7FFFFFFF) || (v == 32'sh80000000);
    endfunction

    assign any_sat = is_lim(o_inv_00) || is_lim(o_inv_01) || is_lim(o_inv_02) ||
                     is_lim(o_inv_10) || is_lim(o_inv_11) || is_lim(o_inv_12) ||
                     is_lim(o_inv_20) || is_lim(o_inv_21) || is_lim(o_inv_22);

    // A singular result is all zeros and never flags overflow.
    `M3I_ASSERT_IMPL(a_sing_zero, i_clk, i_rst_n, o_valid && o_singular, all_zero && !o_overflow)
    // Overflow shows at least one saturated element.
    `M3I_ASSERT_IMPL(a_ovf_lim, i_clk, i_rst_n, o_valid && o_overflow, any_sat)
    // Input backpressure only comes from a held result.
    `M3I_ASSERT_IMPL(a_stall_src, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    // A held result stays in place.
    `M3I_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
                     o_valid && $stable(o_inv_00) && $stable(o_singular))

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (.*);
